### sv/sobel_edge_magnitude_3x3_core_assert.svh
// Assertion macros shared by the Sobel core.
`ifndef SOBEL_EDGE_MAGNITUDE_3X3_CORE_ASSERT_SVH
`define SOBEL_EDGE_MAGNITUDE_3X3_CORE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SOBEL_ASSERT_SAME(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("%m: check failed");

// The consequent must hold in the cycle after the antecedent.
`define SOBEL_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("%m: check failed");

`endif

### sv/sobel_pkg.sv
package sobel_pkg;

    localparam int PIX_W        = 8;
    localparam int ABS_W        = 10;
    localparam int SQ_W         = 2 * ABS_W;
    localparam int SUM_W        = SQ_W + 1;
    localparam int ROOT_W       = 8;
    localparam int WIDTH_REG_W  = 12;
    localparam int HEIGHT_REG_W = 13;
    localparam int ROW_W        = 12;
    localparam int CFG_IDX_W    = 2;
    localparam int CFG_DATA_W   = 13;

    localparam int DEF_MAX_WIDTH = 2048;
    localparam int MAX_ROWS      = 4096;

    localparam logic [WIDTH_REG_W-1:0]  WIDTH_RESET  = 12'd640;
    localparam logic [HEIGHT_REG_W-1:0] HEIGHT_RESET = 13'd480;
    localparam logic [SUM_W-1:0]        SAT_LIMIT    = 21'd65025;
    localparam logic [ROOT_W-1:0]       ROOT_MAX     = 8'd255;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_IMAGE_WIDTH  = 2'd0,
        CFG_IMAGE_HEIGHT = 2'd1
    } cfg_index_t;

    // One result travelling down the square-root chain.
    typedef struct packed {
        logic              valid;
        logic              last;
        logic              sat;
        logic [SUM_W-1:0]  sum;
        logic [ROOT_W-1:0] root;
    } sqrt_lane_t;

endpackage

### sv/sobel_line_buf.sv
module sobel_line_buf
    import sobel_pkg::*;
#(
    parameter int DEPTH = DEF_MAX_WIDTH
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [2*PIX_W-1:0]       wr_data,
    output logic [2*PIX_W-1:0]       rd_data
);

    // Each entry holds the pixel two rows up (high byte) and one row up (low byte).
    logic [2*PIX_W-1:0] mem [DEPTH];
    logic [2*PIX_W-1:0] rd_data_reg;
    logic [2*PIX_W-1:0] byp_data_reg;
    logic               byp_reg;
    logic               collide;

    assign collide = wr_en && (wr_addr == rd_addr);

    always_ff @(posedge aclk) begin
        if (en) begin
            if (wr_en) begin
                mem[wr_addr] <= wr_data;
            end
            rd_data_reg  <= mem[rd_addr];
            byp_data_reg <= wr_data;
        end
    end

    // A read that hits the entry written in the same cycle takes the new data.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            byp_reg <= 1'b0;
        end else if (en) begin
            byp_reg <= collide;
        end
    end

    assign rd_data = byp_reg ? byp_data_reg : rd_data_reg;

endmodule

### sv/sobel_sqrt_cell.sv
module sobel_sqrt_cell
    import sobel_pkg::*;
#(
    parameter int BIT = 0
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       en,
    input  sqrt_lane_t lane_i,
    output sqrt_lane_t lane_o
);

    logic [ROOT_W-1:0]   trial;
    logic [2*ROOT_W-1:0] trial_sq;
    sqrt_lane_t          lane_next;
    sqrt_lane_t          lane_reg;

    always_comb begin
        trial     = lane_i.root | (ROOT_W'(1) << BIT);
        trial_sq  = trial * trial;
        lane_next = lane_i;
        if (SUM_W'(trial_sq) <= lane_i.sum) begin
            lane_next.root = trial;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lane_reg <= '0;
        end else if (en) begin
            lane_reg <= lane_next;
        end
    end

    assign lane_o = lane_reg;

endmodule

### sv/sobel_edge_magnitude_3x3_core.sv
// Sobel 3x3 edge magnitude core: one pixel per cycle in, one result per interior pixel out.
// Pipeline: each pixel passes through read, window, gradient, squares, sum, then eight
// cells of the square-root chain, one result bit per cell.
// Throughput: one pixel per cycle; the whole pipeline holds while the output is stalled.
// Reset: synchronous, active low; clears counters, window, valids and the registers to
// 640 x 480. Line buffer contents are not cleared and need no clearing pass.
`include "sobel_edge_magnitude_3x3_core_assert.svh"

module sobel_edge_magnitude_3x3_core
    import sobel_pkg::*;
#(
    parameter int MAX_WIDTH = DEF_MAX_WIDTH
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [7:0]            s_tdata,   // [7:0] pixel
    input  logic [0:0]            s_tuser,   // [0] frame_start
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [7:0]            m_tdata,   // [7:0] magnitude
    output logic                  m_tlast,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int COL_W  = $clog2(MAX_WIDTH);
    localparam int WEFF_W = $clog2(MAX_WIDTH + 1);
    localparam int CMP_W  = (WEFF_W > WIDTH_REG_W) ? WEFF_W : WIDTH_REG_W;

    // Configuration.
    logic [WIDTH_REG_W-1:0]  image_width_reg;
    logic [HEIGHT_REG_W-1:0] image_height_reg;
    logic                    cfg_write;

    assign cfg_ready = 1'b1;
    assign cfg_write = cfg_valid && cfg_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            image_width_reg  <= WIDTH_RESET;
            image_height_reg <= HEIGHT_RESET;
        end else if (cfg_write) begin
            case (cfg_index)
                CFG_IMAGE_WIDTH:  image_width_reg  <= cfg_data[WIDTH_REG_W-1:0];
                CFG_IMAGE_HEIGHT: image_height_reg <= cfg_data[HEIGHT_REG_W-1:0];
                default: ;
            endcase
        end
    end

    logic [CMP_W-1:0]        width_ext;
    logic [CMP_W-1:0]        w_eff;
    logic [HEIGHT_REG_W-1:0] h_eff;

    always_comb begin
        width_ext = CMP_W'(image_width_reg);
        if (width_ext < CMP_W'(3)) begin
            w_eff = CMP_W'(3);
        end else if (width_ext > CMP_W'(MAX_WIDTH)) begin
            w_eff = CMP_W'(MAX_WIDTH);
        end else begin
            w_eff = width_ext;
        end
        if (image_height_reg < HEIGHT_REG_W'(3)) begin
            h_eff = HEIGHT_REG_W'(3);
        end else if (image_height_reg > HEIGHT_REG_W'(MAX_ROWS)) begin
            h_eff = HEIGHT_REG_W'(MAX_ROWS);
        end else begin
            h_eff = image_height_reg;
        end
    end

    // Pipeline control: everything moves together unless the result is stalled.
    logic advance;
    logic accept;

    assign advance  = !m_tvalid || m_tready;
    assign s_tready = advance;
    assign accept   = s_tvalid && s_tready;

    // Position of the incoming pixel.
    logic [COL_W-1:0]        col_reg;
    logic [COL_W-1:0]        col_next;
    logic [ROW_W-1:0]        row_reg;
    logic [ROW_W-1:0]        row_next;
    logic [CMP_W-1:0]        col_a;
    logic [HEIGHT_REG_W-1:0] row_a;
    logic [COL_W-1:0]        col_cur;
    logic [ROW_W-1:0]        row_cur;
    logic                    interior;
    logic                    frame_end;

    always_comb begin
        col_a = s_tuser[0] ? '0 : CMP_W'(col_reg);
        row_a = s_tuser[0] ? '0 : HEIGHT_REG_W'(row_reg);
        if (row_a >= h_eff) begin
            row_a = '0;
            col_a = '0;
        end
        if (col_a >= w_eff) begin
            col_a = '0;
            row_a = (row_a + HEIGHT_REG_W'(1) >= h_eff) ? '0 : row_a + HEIGHT_REG_W'(1);
        end
        col_cur   = col_a[COL_W-1:0];
        row_cur   = row_a[ROW_W-1:0];
        interior  = (row_cur >= ROW_W'(2)) && (col_cur >= COL_W'(2));
        frame_end = (row_a == h_eff - HEIGHT_REG_W'(1)) && (col_a == w_eff - CMP_W'(1));
        if (col_a + CMP_W'(1) >= w_eff) begin
            col_next = '0;
            row_next = (row_a + HEIGHT_REG_W'(1) >= h_eff) ? '0 : row_cur + ROW_W'(1);
        end else begin
            col_next = col_cur + COL_W'(1);
            row_next = row_cur;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg <= '0;
            row_reg <= '0;
        end else if (accept) begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    // Stage 1: line buffer read returns, read-modify-write of the column.
    logic             v1_reg;
    logic             int1_reg;
    logic             last1_reg;
    logic [PIX_W-1:0] px1_reg;
    logic [COL_W-1:0] addr1_reg;
    logic [2*PIX_W-1:0] lb_rd_data;
    logic [PIX_W-1:0] top;
    logic [PIX_W-1:0] mid;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
        end else if (advance) begin
            v1_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            int1_reg  <= interior;
            last1_reg <= frame_end;
            px1_reg   <= s_tdata;
            addr1_reg <= col_cur;
        end
    end

    sobel_line_buf #(
        .DEPTH (MAX_WIDTH)
    ) u_line_buf (
        .aclk    (aclk),
        .aresetn (aresetn),
        .en      (advance),
        .rd_addr (col_cur),
        .wr_en   (v1_reg),
        .wr_addr (addr1_reg),
        .wr_data ({mid, px1_reg}),
        .rd_data (lb_rd_data)
    );

    assign top = lb_rd_data[2*PIX_W-1:PIX_W];
    assign mid = lb_rd_data[PIX_W-1:0];

    // Window: row 0 is two rows up, column 2 is the newest column.
    logic [PIX_W-1:0] win_reg [3][3];
    logic             vw_reg;
    logic             lastw_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int r = 0; r < 3; r++) begin
                for (int c = 0; c < 3; c++) begin
                    win_reg[r][c] <= '0;
                end
            end
        end else if (advance && v1_reg) begin
            for (int r = 0; r < 3; r++) begin
                win_reg[r][0] <= win_reg[r][1];
                win_reg[r][1] <= win_reg[r][2];
            end
            win_reg[0][2] <= top;
            win_reg[1][2] <= mid;
            win_reg[2][2] <= px1_reg;
        end
    end

    // Stage 2: absolute gradients from the window.
    logic [ABS_W-1:0] pos_x;
    logic [ABS_W-1:0] neg_x;
    logic [ABS_W-1:0] pos_y;
    logic [ABS_W-1:0] neg_y;
    logic [ABS_W-1:0] abs_x;
    logic [ABS_W-1:0] abs_y;
    logic [ABS_W-1:0] absx_reg;
    logic [ABS_W-1:0] absy_reg;
    logic             vg_reg;
    logic             lastg_reg;

    always_comb begin
        pos_x = ABS_W'(win_reg[0][2]) + ABS_W'({win_reg[1][2], 1'b0}) + ABS_W'(win_reg[2][2]);
        neg_x = ABS_W'(win_reg[0][0]) + ABS_W'({win_reg[1][0], 1'b0}) + ABS_W'(win_reg[2][0]);
        pos_y = ABS_W'(win_reg[2][0]) + ABS_W'({win_reg[2][1], 1'b0}) + ABS_W'(win_reg[2][2]);
        neg_y = ABS_W'(win_reg[0][0]) + ABS_W'({win_reg[0][1], 1'b0}) + ABS_W'(win_reg[0][2]);
        abs_x = (pos_x >= neg_x) ? pos_x - neg_x : neg_x - pos_x;
        abs_y = (pos_y >= neg_y) ? pos_y - neg_y : neg_y - pos_y;
    end

    // Stage 3: squares. Stage 4: sum and saturation, which enters the root chain.
    logic [SQ_W-1:0]  sqx_reg;
    logic [SQ_W-1:0]  sqy_reg;
    logic             vq_reg;
    logic             lastq_reg;
    logic [SUM_W-1:0] sum;
    sqrt_lane_t       lane_in_reg;
    sqrt_lane_t       lanes [ROOT_W+1];

    assign sum = SUM_W'(sqx_reg) + SUM_W'(sqy_reg);

    always_ff @(posedge aclk) begin
        if (advance) begin
            lastw_reg <= last1_reg;
            absx_reg  <= abs_x;
            absy_reg  <= abs_y;
            lastg_reg <= lastw_reg;
            sqx_reg   <= absx_reg * absx_reg;
            sqy_reg   <= absy_reg * absy_reg;
            lastq_reg <= lastg_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vw_reg      <= 1'b0;
            vg_reg      <= 1'b0;
            vq_reg      <= 1'b0;
            lane_in_reg <= '0;
        end else if (advance) begin
            vw_reg           <= v1_reg && int1_reg;
            vg_reg           <= vw_reg;
            vq_reg           <= vg_reg;
            lane_in_reg.valid <= vq_reg;
            lane_in_reg.last  <= lastq_reg;
            lane_in_reg.sat   <= (sum >= SAT_LIMIT);
            lane_in_reg.sum   <= sum;
            lane_in_reg.root  <= '0;
        end
    end

    assign lanes[0] = lane_in_reg;

    // One cell per result bit, most significant first.
    for (genvar k = 0; k < ROOT_W; k++) begin : g_cell
        sobel_sqrt_cell #(
            .BIT (ROOT_W - 1 - k)
        ) u_cell (
            .aclk    (aclk),
            .aresetn (aresetn),
            .en      (advance),
            .lane_i  (lanes[k]),
            .lane_o  (lanes[k+1])
        );
    end

    assign m_tvalid = lanes[ROOT_W].valid;
    assign m_tlast  = lanes[ROOT_W].last;
    assign m_tdata  = lanes[ROOT_W].sat ? ROOT_MAX : lanes[ROOT_W].root;

    // Checks.
    logic [2*ROOT_W+1:0] root_sq;
    logic [2*ROOT_W+1:0] root1_sq;

    assign root_sq  = (2*ROOT_W+2)'(lanes[ROOT_W].root) * (2*ROOT_W+2)'(lanes[ROOT_W].root);
    assign root1_sq = ((2*ROOT_W+2)'(lanes[ROOT_W].root) + (2*ROOT_W+2)'(1))
                    * ((2*ROOT_W+2)'(lanes[ROOT_W].root) + (2*ROOT_W+2)'(1));

    `SOBEL_ASSERT_SAME(a_stall_holds_input, aclk, aresetn, m_tvalid && !m_tready, !s_tready)
    `SOBEL_ASSERT_NEXT(a_col_in_range, aclk, aresetn, accept && !cfg_write, CMP_W'(col_reg) < w_eff)
    `SOBEL_ASSERT_SAME(a_root_exact, aclk, aresetn, m_tvalid && !lanes[ROOT_W].sat,
        (SUM_W'(root_sq) <= lanes[ROOT_W].sum) && (SUM_W'(root1_sq) > lanes[ROOT_W].sum))

endmodule
